[rtl/h2r_pkg.sv]
// ----------------------------------------------------------------------------
// HLS to RGB converter package
// Shared types, constants and a helper function of the converter.
// ----------------------------------------------------------------------------
package h2r_pkg;

  localparam logic [8:0]  HueMax     = 9'd360;
  localparam logic [8:0]  HueThird   = 9'd120;
  localparam logic [8:0]  HueTwoThd  = 9'd240;
  localparam logic [6:0]  PctMax     = 7'd100;
  localparam logic [6:0]  DarkLimit  = 7'd50;
  localparam logic [23:0] RoundBias  = 24'd20000;
  localparam logic [18:0] Recip      = 19'd429497;
  localparam int          RecipShift = 28;
  localparam int          QDepth     = 2;
  localparam int          QAw        = $clog2(QDepth);
  localparam int          QCw        = $clog2(QDepth + 1);
  localparam int          NumChan    = 3;

  typedef struct packed {
    logic [8:0] hue_deg;
    logic [6:0] lightness_pct;
    logic [6:0] saturation_pct;
  } h2r_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } h2r_rsp_t;

  typedef struct packed {
    logic [8:0]  hue;
    logic [13:0] q_lvl;
    logic [13:0] p_lvl;
  } h2r_ent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } h2r_qstat_t;

  // Weight of the level difference on the piecewise hue ramp, 0..60.
  function automatic logic [5:0] h2r_ramp(input logic [8:0] t);
    logic [5:0] m;
    if (t < 9'd60) begin
      m = t[5:0];
    end else if (t < 9'd180) begin
      m = 6'd60;
    end else if (t < HueTwoThd) begin
      m = 6'(HueTwoThd - t);
    end else begin
      m = '0;
    end
    return m;
  endfunction

endpackage

[rtl/h2r_front.sv]
// ----------------------------------------------------------------------------
// HLS to RGB converter front end
// Takes a request, clamps its fields and forms the two lightness levels.
// ----------------------------------------------------------------------------
module h2r_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  h2r_pkg::h2r_req_t   req_i,
  input  h2r_pkg::h2r_qstat_t qstat_i,
  output logic                push_o,
  output h2r_pkg::h2r_ent_t   ent_o
);
  import h2r_pkg::*;

  logic       fr_vld_q, fr_vld_d;
  h2r_req_t   fr_req_q;
  logic       accept;
  logic [8:0] hue;
  logic [6:0] lgt;
  logic [6:0] sat;
  logic [13:0] q_lvl;
  logic [14:0] l200;

  assign accept = start_i && !qstat_i.full;
  assign push_o = fr_vld_q && !qstat_i.full;

  always_comb begin
    fr_vld_d = fr_vld_q;
    if (accept) begin
      fr_vld_d = 1'b1;
    end else if (push_o) begin
      fr_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_vld_q <= 1'b0;
    end else begin
      fr_vld_q <= fr_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fr_req_q <= req_i;
    end
  end

  always_comb begin
    hue = (fr_req_q.hue_deg > HueMax) ? HueMax : fr_req_q.hue_deg;
    lgt = (fr_req_q.lightness_pct > PctMax) ? PctMax : fr_req_q.lightness_pct;
    sat = (fr_req_q.saturation_pct > PctMax) ? PctMax : fr_req_q.saturation_pct;
    if (lgt < DarkLimit) begin
      q_lvl = 14'(15'(lgt) * (15'(PctMax) + 15'(sat)));
    end else begin
      q_lvl = 14'(15'(lgt) * 15'(PctMax) + 15'(sat) * 15'(PctMax - lgt));
    end
    l200 = 15'(lgt) * 15'd200;
    ent_o.hue   = hue;
    ent_o.q_lvl = q_lvl;
    ent_o.p_lvl = 14'(l200 - 15'(q_lvl));
  end

endmodule

[rtl/h2r_queue.sv]
// ----------------------------------------------------------------------------
// HLS to RGB converter queue
// Short register queue between the front end and the channel datapath.
// ----------------------------------------------------------------------------
module h2r_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  h2r_pkg::h2r_ent_t   ent_i,
  input  logic                pop_i,
  output h2r_pkg::h2r_ent_t   ent_o,
  output h2r_pkg::h2r_qstat_t qstat_o
);
  import h2r_pkg::*;

  h2r_ent_t       mem_q [QDepth];
  logic [QAw-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCw-1:0] cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign qstat_o.full  = (cnt_q == QCw'(QDepth));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !qstat_o.full;
  assign do_pop  = pop_i && !qstat_o.empty;
  assign ent_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? QAw'(wr_q + 1'b1) : wr_q;
    rd_d  = do_pop ? QAw'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = QCw'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = QCw'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= ent_i;
    end
  end

endmodule

[rtl/h2r_back.sv]
// ----------------------------------------------------------------------------
// HLS to RGB converter back end
// Three-stage channel datapath: hue ramp, rounding, scaling to 0..255.
// ----------------------------------------------------------------------------
module h2r_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  h2r_pkg::h2r_ent_t   ent_i,
  input  h2r_pkg::h2r_qstat_t qstat_i,
  output logic                pop_o,
  output logic                strobe_o,
  output h2r_pkg::h2r_rsp_t   rsp_o
);
  import h2r_pkg::*;

  logic [8:0]  t_ch [NumChan];
  logic [9:0]  hue_up;
  logic [13:0] diff;
  logic [19:0] p60;
  logic [19:0] n_d [NumChan];
  logic [19:0] n_q [NumChan];
  logic [17:0] y_d [NumChan];
  logic [17:0] y_q [NumChan];
  logic [36:0] prod [NumChan];
  logic [7:0]  res_d [NumChan];
  logic [7:0]  res_q [NumChan];
  logic        v1_q, v2_q, v3_q;

  assign pop_o = !qstat_i.empty;

  always_comb begin
    hue_up = 10'(ent_i.hue) + 10'(HueThird);
    t_ch[0] = (hue_up > 10'(HueMax)) ? 9'(hue_up - 10'(HueMax)) : hue_up[8:0];
    t_ch[1] = ent_i.hue;
    t_ch[2] = (ent_i.hue < HueThird) ? 9'(ent_i.hue + HueTwoThd)
                                     : 9'(ent_i.hue - HueThird);
    diff = 14'(ent_i.q_lvl - ent_i.p_lvl);
    p60  = 20'(ent_i.p_lvl) * 20'd60;
    for (int c = 0; c < NumChan; c++) begin
      n_d[c]   = p60 + 20'(diff) * 20'(h2r_ramp(t_ch[c]));
      y_d[c]   = 18'((24'(n_q[c]) * 24'd17 + RoundBias) >> 6);
      prod[c]  = 37'(y_q[c]) * 37'(Recip);
      res_d[c] = prod[c][RecipShift+7:RecipShift];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= pop_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    y_q   <= y_d;
    res_q <= res_d;
  end

  assign strobe_o    = v3_q;
  assign rsp_o.red   = res_q[0];
  assign rsp_o.green = res_q[1];
  assign rsp_o.blue  = res_q[2];

endmodule

[rtl/hls_to_rgb_converter_core.sv]
// ----------------------------------------------------------------------------
// HLS to RGB converter core
// Converts hue, lightness and saturation to 8-bit red, green and blue.
// ----------------------------------------------------------------------------
//  Channel   Ports                     Handshake
//  request   start, busy, req_i        taken when start is high and busy low
//  result    strobe, result_o          valid for one cycle, cannot be held off
//
//  A request enters every cycle; its result passes the front register, the queue
//  and the three channel stages before it shows on strobe and result_o.
//  Reset empties the front register, the queue and the channel pipeline.
//  The channel datapath never stalls, so busy stays low in operation.
// ----------------------------------------------------------------------------
module hls_to_rgb_converter_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  h2r_pkg::h2r_req_t req_i,
  output logic              busy,
  output logic              strobe,
  output h2r_pkg::h2r_rsp_t result_o
);
  import h2r_pkg::*;

  h2r_qstat_t qstat;
  h2r_ent_t   push_ent;
  h2r_ent_t   head_ent;
  logic       push;
  logic       pop;

  assign busy = qstat.full;

  h2r_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req_i),
    .qstat_i (qstat),
    .push_o  (push),
    .ent_o   (push_ent)
  );

  h2r_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (push_ent),
    .pop_i   (pop),
    .ent_o   (head_ent),
    .qstat_o (qstat)
  );

  h2r_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ent_i    (head_ent),
    .qstat_i  (qstat),
    .pop_o    (pop),
    .strobe_o (strobe),
    .rsp_o    (result_o)
  );

endmodule

[rtl/h2r_checker.sv]
// ----------------------------------------------------------------------------
// HLS to RGB converter checker
// Port-level checks of latency, flow and grey output, bound to the core.
// ----------------------------------------------------------------------------
module h2r_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input h2r_pkg::h2r_req_t req_i,
  input logic              busy,
  input logic              strobe,
  input h2r_pkg::h2r_rsp_t result_o
);
  import h2r_pkg::*;

  logic taken;
  assign taken = start && !busy;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken |-> ##5 strobe)
    else $error("request without result after five cycles");

  a_no_extra : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> $past(taken, 5))
    else $error("result without a matching request");

  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised although the datapath never stalls");

  a_grey : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && $past(taken && (req_i.saturation_pct == '0), 5)
      |-> (result_o.red == result_o.green) && (result_o.green == result_o.blue))
    else $error("zero saturation did not give grey");

endmodule

bind hls_to_rgb_converter_core h2r_checker u_h2r_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .req_i    (req_i),
  .busy     (busy),
  .strobe   (strobe),
  .result_o (result_o)
);

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// HLS to RGB converter testbench
// Sends directed and random color requests to the converter core, predicts
// each red, green and blue result in integer arithmetic and checks every
// strobed result against the oldest prediction, with random sender idling.
// ----------------------------------------------------------------------------
module tb_top;
  import h2r_pkg::*;

  typedef struct {
    h2r_req_t req;
    int       gap;
  } color_item_t;

  localparam int NumRandom = 1800;
  localparam int CalmTail  = 300;
  localparam int DrainCyc  = 20;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  h2r_req_t req_i  = '0;
  logic     busy;
  logic     strobe;
  h2r_rsp_t result_o;

  color_item_t color_queue[$];
  h2r_rsp_t    rgb_expected[$];
  int          next_idx   = 0;
  int          idle_left  = 0;
  int          err_cnt    = 0;
  int          rsp_cnt    = 0;

  hls_to_rgb_converter_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .req_i   (req_i),
    .busy    (busy),
    .strobe  (strobe),
    .result_o(result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] ramp_level(longint p_lvl, longint q_lvl, int t);
    longint n;
    if (t < 0) begin
      t = t + 360;
    end
    if (t > 360) begin
      t = t - 360;
    end
    if (t < 60) begin
      n = 60 * p_lvl + (q_lvl - p_lvl) * t;
    end else if (t < 180) begin
      n = 60 * q_lvl;
    end else if (t < 240) begin
      n = 60 * p_lvl + (q_lvl - p_lvl) * (240 - t);
    end else begin
      n = 60 * p_lvl;
    end
    return 8'((n * 255 + 300000) / 600000);
  endfunction

  function automatic h2r_rsp_t predict_rgb(h2r_req_t req);
    int       h;
    longint   l;
    longint   s;
    longint   q_lvl;
    longint   p_lvl;
    h2r_rsp_t rsp;
    h = (req.hue_deg > 9'd360) ? 360 : int'(req.hue_deg);
    l = (req.lightness_pct > 7'd100) ? 100 : longint'(req.lightness_pct);
    s = (req.saturation_pct > 7'd100) ? 100 : longint'(req.saturation_pct);
    if (l < 50) begin
      q_lvl = l * (100 + s);
    end else begin
      q_lvl = 100 * l + s * (100 - l);
    end
    p_lvl = 200 * l - q_lvl;
    rsp.red   = ramp_level(p_lvl, q_lvl, h + 120);
    rsp.green = ramp_level(p_lvl, q_lvl, h);
    rsp.blue  = ramp_level(p_lvl, q_lvl, h - 120);
    return rsp;
  endfunction

  task automatic add_color(int h, int l, int s, int gap);
    color_item_t it;
    it.req.hue_deg        = 9'(h);
    it.req.lightness_pct  = 7'(l);
    it.req.saturation_pct = 7'(s);
    it.gap                = gap;
    color_queue.push_back(it);
  endtask

  // Driver: a request moves at an edge where start is high and busy is low.
  always @(posedge clk_i) begin
    logic     fire;
    logic     nxt_start;
    h2r_req_t nxt_req;
    if (rst_ni) begin
      fire      = start && !busy;
      nxt_start = start && !fire;
      nxt_req   = req_i;
      if (fire) begin
        rgb_expected.push_back(predict_rgb(req_i));
        next_idx = next_idx + 1;
        idle_left = (next_idx < color_queue.size()) ? color_queue[next_idx].gap : 0;
      end
      if (!start || fire) begin
        if (idle_left > 0) begin
          idle_left = idle_left - 1;
          nxt_start = 1'b0;
        end else if (next_idx < color_queue.size()) begin
          nxt_start = 1'b1;
          nxt_req   = color_queue[next_idx].req;
        end
      end
      start <= nxt_start;
      req_i <= nxt_req;
    end
  end

  // Monitor: results cannot be held off, so every strobe is checked.
  always @(posedge clk_i) begin
    h2r_rsp_t exp_rsp;
    if (rst_ni && strobe) begin
      rsp_cnt = rsp_cnt + 1;
      if (rgb_expected.size() == 0) begin
        $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
                 result_o.red, result_o.green, result_o.blue);
        err_cnt = err_cnt + 1;
      end else begin
        exp_rsp = rgb_expected.pop_front();
        if (result_o.red !== exp_rsp.red) begin
          $display("%0t: red mismatch expected %0d actual %0d", $time,
                   exp_rsp.red, result_o.red);
          err_cnt = err_cnt + 1;
        end
        if (result_o.green !== exp_rsp.green) begin
          $display("%0t: green mismatch expected %0d actual %0d", $time,
                   exp_rsp.green, result_o.green);
          err_cnt = err_cnt + 1;
        end
        if (result_o.blue !== exp_rsp.blue) begin
          $display("%0t: blue mismatch expected %0d actual %0d", $time,
                   exp_rsp.blue, result_o.blue);
          err_cnt = err_cnt + 1;
        end
      end
    end
  end

  initial begin
    int borders[11];
    int sel;
    int gap;
    bit idling;
    borders = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 359, 360};
    // Extremes, hue segment borders, out-of-range clamps and gray.
    add_color(0, 0, 0, 0);
    add_color(360, 100, 100, 0);
    add_color(511, 127, 127, 0);
    add_color(361, 50, 100, 0);
    add_color(0, 50, 100, 0);
    add_color(60, 50, 100, 0);
    add_color(120, 50, 100, 0);
    add_color(180, 50, 100, 0);
    add_color(239, 50, 100, 0);
    add_color(240, 50, 100, 0);
    add_color(359, 50, 100, 0);
    add_color(30, 49, 100, 0);
    add_color(30, 50, 73, 0);
    add_color(200, 25, 0, 0);
    add_color(200, 100, 0, 0);
    add_color(300, 1, 1, 0);
    add_color(90, 99, 99, 0);
    add_color(150, 101, 50, 0);
    add_color(210, 50, 101, 0);
    add_color(256, 64, 64, 0);
    add_color(255, 63, 63, 0);
    idling = 1'b1;
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 64 == 0) begin
        idling = ($urandom_range(0, 2) != 0);
      end
      gap = 0;
      if (idling && i < NumRandom - CalmTail && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 17);
      end
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        add_color($urandom_range(0, 360), $urandom_range(0, 100), $urandom_range(0, 100), gap);
      end else if (sel < 9) begin
        add_color(borders[$urandom_range(0, 10)], $urandom_range(0, 100),
                  $urandom_range(0, 100), gap);
      end else begin
        add_color($urandom_range(0, 511), $urandom_range(0, 127), $urandom_range(0, 127), gap);
      end
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (next_idx < color_queue.size() || rgb_expected.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCyc) @(posedge clk_i);
    $display("Converted %0d colors: extremes, hue segment borders, out-of-range clamps, gray.",
             color_queue.size());
    $display("Checked %0d results with random request idling in bursts.", rsp_cnt);
    if (err_cnt == 0 && rgb_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/h2r_pkg.sv
rtl/h2r_front.sv
rtl/h2r_queue.sv
rtl/h2r_back.sv
rtl/hls_to_rgb_converter_core.sv
rtl/h2r_checker.sv
verif/tb_top.sv
